[src/pxb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxb_pkg
// Shared types, register indexes and the half-float decoder for the pixel
// byte serializer.
// ----------------------------------------------------------------------------
package pxb_pkg;

    // Register indexes of the configuration port.
    localparam logic [0:0] CFG_MODE16 = 1'b0;
    localparam logic [0:0] CFG_GRAY   = 1'b1;

    // Most bytes a single pixel can produce, and the width of a byte count.
    localparam int MAX_BYTES  = 6;
    localparam int BYTE_CNT_W = 3;

    // Width of a finite half value held exactly in units of 2^-24 (signed).
    localparam int HALF_VAL_W = 41;

    // Class of a decoded half-float code.
    typedef enum logic [1:0] {
        KIND_FINITE = 2'd0,
        KIND_PINF   = 2'd1,
        KIND_NINF   = 2'd2,
        KIND_NAN    = 2'd3
    } pxb_kind_t;

    // Decoded half: class plus exact value for finite codes.
    typedef struct packed {
        pxb_kind_t                      kind;
        logic signed [HALF_VAL_W-1:0]   val;
    } pxb_half_t;

    // All bytes of one pixel, with how many of them are used.
    typedef struct packed {
        logic [BYTE_CNT_W-1:0]          count;
        logic [MAX_BYTES-1:0][7:0]      bytes;
    } pxb_bytes_t;

    // Decodes a half code into its class and exact value in units of 2^-24.
    function automatic pxb_half_t pxb_decode(input logic [15:0] code);
        pxb_half_t         h;
        logic [HALF_VAL_W-2:0] mag;
        h.kind = KIND_FINITE;
        h.val  = '0;
        mag    = '0;
        if (code[14:10] == 5'h1F)
        begin
            if (code[9:0] != 10'd0)
                h.kind = KIND_NAN;
            else if (code[15])
                h.kind = KIND_NINF;
            else
                h.kind = KIND_PINF;
        end
        else
        begin
            if (code[14:10] == 5'd0)
                mag = {30'd0, code[9:0]};
            else
                mag = {29'd0, 1'b1, code[9:0]} << (code[14:10] - 5'd1);
            if (code[15])
                h.val = -$signed({1'b0, mag});
            else
                h.val = $signed({1'b0, mag});
        end
        return h;
    endfunction

endpackage

[src/pxb_conv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxb_conv
// Three-stage conversion pipeline: decode, per-channel scaling and gray sum,
// then gray scaling and byte packing.
// ----------------------------------------------------------------------------
module pxb_conv
    import pxb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        mode16,
    input  logic        gray,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pxb_bytes_t  out_item
);

    localparam int GSUM_W = HALF_VAL_W + 2;
    // Three times 1.0 in units of 2^-24.
    localparam logic [GSUM_W-2:0] THREE_ONE = (GSUM_W-1)'(3 * (1 << 24));

    // Stage registers.
    logic                  v1_reg, v2_reg, v3_reg;
    logic                  m16_1_reg, gr_1_reg, m16_2_reg, gr_2_reg;
    pxb_half_t [2:0]       half1_reg;
    logic [2:0][7:0]       raw1_reg, raw2_reg;
    logic [9:0]            sum8_1_reg;
    logic [2:0][15:0]      ch16_2_reg;
    logic signed [GSUM_W-1:0] gsum2_reg;
    logic                  gfull2_reg, gzero2_reg;
    logic [19:0]           q8_2_reg;
    pxb_bytes_t            item3_reg;

    // Next values.
    pxb_half_t [2:0]       half1_next;
    logic [2:0][7:0]       raw1_next;
    logic [9:0]            sum8_1_next;
    logic [2:0][15:0]      ch16_2_next;
    logic signed [GSUM_W-1:0] gsum2_next;
    logic                  gfull2_next, gzero2_next;
    logic [19:0]           q8_2_next;
    pxb_bytes_t            item3_next;

    logic                  st1_ready, st2_ready, st3_ready;

    // Each stage moves when it is empty or the stage after it moves.
    assign st3_ready = !v3_reg || out_ready;
    assign st2_ready = !v2_reg || st3_ready;
    assign st1_ready = !v1_reg || st2_ready;
    assign in_ready  = st1_ready;
    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

    // Stage one: decode the three half codes and add the byte channels.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            half1_next[i] = pxb_decode(in_data[16*i +: 16]);
            raw1_next[i]  = in_data[16*i +: 8];
        end
        sum8_1_next = {2'b00, in_data[7:0]} + {2'b00, in_data[23:16]}
                    + {2'b00, in_data[39:32]};
    end

    // Stage two: clamp and scale each channel, sum the finite values.
    always_comb
    begin
        logic [23:0] v24;
        logic [39:0] t;
        v24         = '0;
        t           = '0;
        gsum2_next  = '0;
        gfull2_next = 1'b0;
        gzero2_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            v24 = half1_reg[i].val[23:0];
            t   = {v24, 16'h0000} - {16'h0000, v24};
            if (half1_reg[i].kind == KIND_NAN || half1_reg[i].kind == KIND_PINF)
                ch16_2_next[i] = 16'hFFFF;
            else if (half1_reg[i].kind == KIND_NINF || half1_reg[i].val[HALF_VAL_W-1]
                     || half1_reg[i].val == '0)
                ch16_2_next[i] = 16'h0000;
            else if (|half1_reg[i].val[HALF_VAL_W-2:24])
                ch16_2_next[i] = 16'hFFFF;
            else
                ch16_2_next[i] = t[39:24];

            if (half1_reg[i].kind == KIND_FINITE)
                gsum2_next = gsum2_next + GSUM_W'(half1_reg[i].val);
            if (half1_reg[i].kind == KIND_NAN || half1_reg[i].kind == KIND_PINF)
                gfull2_next = 1'b1;
            if (half1_reg[i].kind == KIND_NINF)
                gzero2_next = 1'b1;
        end
        // Byte average: multiply by 683 / 2048, exact for sums up to 765.
        q8_2_next = {10'd0, sum8_1_reg} * 20'd683;
    end

    // Stage three: scale the gray sum and pack the bytes of the pixel.
    always_comb
    begin
        logic [40:0] prod;
        logic [15:0] g16;
        prod = {15'd0, gsum2_reg[25:0]} * 41'd21845;
        if (gfull2_reg)
            g16 = 16'hFFFF;
        else if (gzero2_reg || gsum2_reg[GSUM_W-1] || gsum2_reg == '0)
            g16 = 16'h0000;
        else if (gsum2_reg[GSUM_W-2:0] >= THREE_ONE)
            g16 = 16'hFFFF;
        else
            g16 = prod[39:24];

        item3_next.bytes = '0;
        if (!m16_2_reg && gr_2_reg)
        begin
            item3_next.count    = BYTE_CNT_W'(1);
            item3_next.bytes[0] = q8_2_reg[18:11];
        end
        else if (!m16_2_reg)
        begin
            item3_next.count    = BYTE_CNT_W'(3);
            item3_next.bytes[0] = raw2_reg[0];
            item3_next.bytes[1] = raw2_reg[1];
            item3_next.bytes[2] = raw2_reg[2];
        end
        else if (gr_2_reg)
        begin
            item3_next.count    = BYTE_CNT_W'(2);
            item3_next.bytes[0] = g16[7:0];
            item3_next.bytes[1] = g16[15:8];
        end
        else
        begin
            item3_next.count = BYTE_CNT_W'(6);
            for (int i = 0; i < 3; i++)
            begin
                item3_next.bytes[2*i]   = ch16_2_reg[i][7:0];
                item3_next.bytes[2*i+1] = ch16_2_reg[i][15:8];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
                v1_reg <= in_valid;
            if (st2_ready)
                v2_reg <= v1_reg;
            if (st3_ready)
                v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (st1_ready)
        begin
            m16_1_reg  <= mode16;
            gr_1_reg   <= gray;
            half1_reg  <= half1_next;
            raw1_reg   <= raw1_next;
            sum8_1_reg <= sum8_1_next;
        end
        if (st2_ready)
        begin
            m16_2_reg  <= m16_1_reg;
            gr_2_reg   <= gr_1_reg;
            raw2_reg   <= raw1_reg;
            ch16_2_reg <= ch16_2_next;
            gsum2_reg  <= gsum2_next;
            gfull2_reg <= gfull2_next;
            gzero2_reg <= gzero2_next;
            q8_2_reg   <= q8_2_next;
        end
        if (st3_ready)
            item3_reg <= item3_next;
    end

endmodule

[src/pxb_ser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxb_ser
// Byte serializer: holds the bytes of one pixel and sends them one per
// item, flagging the final byte.
// ----------------------------------------------------------------------------
module pxb_ser
    import pxb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pxb_bytes_t  in_item,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic                  full_reg, full_next;
    logic [BYTE_CNT_W-1:0] idx_reg, idx_next;
    pxb_bytes_t            buf_reg;
    logic                  load, send;

    assign m_tvalid = full_reg;
    assign m_tdata  = buf_reg.bytes[idx_reg];
    assign m_tlast  = (idx_reg == buf_reg.count - BYTE_CNT_W'(1));
    assign send     = full_reg && m_tready;
    // A new pixel loads while the last byte of the previous one leaves.
    assign in_ready = !full_reg || (m_tready && m_tlast);
    assign load     = in_valid && in_ready;

    // Fill state and byte index.
    always_comb
    begin
        full_next = full_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            full_next = 1'b1;
            idx_next  = '0;
        end
        else if (send && m_tlast)
            full_next = 1'b0;
        else if (send)
            idx_next = idx_reg + BYTE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            full_reg <= full_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= in_item;
    end

    // The index never runs past the pixel's byte count.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (idx_reg < buf_reg.count))
        else $error("byte index beyond pixel byte count");

    // A held pixel always has one of the legal byte counts.
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (buf_reg.count == BYTE_CNT_W'(1) || buf_reg.count == BYTE_CNT_W'(2)
                      || buf_reg.count == BYTE_CNT_W'(3) || buf_reg.count == BYTE_CNT_W'(6)))
        else $error("illegal pixel byte count");

    // After a byte that is not the last, the next byte of the same pixel follows.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && idx_reg == $past(idx_reg) + BYTE_CNT_W'(1)))
        else $error("serializer lost or repeated a byte");

    // A pixel never loads over one whose bytes are still being sent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !load)
        else $error("pixel loaded over unsent bytes");

endmodule

[src/pixel_to_image_message_bytes_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_image_message_bytes_core
// Turns RGB pixels into the data bytes of an image message.
// ----------------------------------------------------------------------------
// Usage:
// - Input stream (s_t*): one RGB pixel per item. Output stream (m_t*): one
//   byte per item, m_tlast high on the final byte of each pixel.
// - Configuration port: cfg_we writes cfg_data into register cfg_index
//   (0 = sixteen-bit mode, 1 = grayscale). Write only while the block is idle.
// - 8-bit mode gives R, G, B or the floor of their average; 16-bit mode reads
//   half-float channels and gives clamped, scaled 16-bit values, low byte first.
// - An accepted pixel passes three conversion stages, then the byte serializer,
//   before its first byte is valid.
// - A pixel gives 1, 3, 2 or 6 bytes for 8-bit gray, 8-bit RGB, 16-bit gray
//   and 16-bit RGB; the one-byte output channel sets the pixel rate.
//   The pipeline takes a new pixel every cycle while the serializer keeps up.
// - Reset clears both registers to zero and empties the pipeline.
// - When the receiver stalls, bytes hold on m_tdata and the pipeline fills,
//   then s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pixel_to_image_message_bytes_core
    import pxb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // red [15:0], green [31:16], blue [47:32]
    // Byte output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // data_byte [7:0]
    output logic        m_tlast
);

    logic       mode16_reg, gray_reg;
    logic       conv_valid, conv_ready;
    pxb_bytes_t conv_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode16_reg <= 1'b0;
            gray_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE16: mode16_reg <= cfg_data[0];
                CFG_GRAY:   gray_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Conversion pipeline.
    pxb_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode16    (mode16_reg),
        .gray      (gray_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_item  (conv_item)
    );

    // Byte serializer.
    pxb_ser u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (conv_valid),
        .in_ready (conv_ready),
        .in_item  (conv_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel byte serializer. Pixels go in through the
// input stream under bursty traffic, the bytes that come out are compared
// in order against a local model of the conversion, and the receiver
// applies back pressure on a changing pattern. All four register settings
// are covered, each first with edge values and then with random pixels.
// ----------------------------------------------------------------------------
module tb;
    import pxb_pkg::*;

    // One expected output byte.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } pixel_byte_t;

    localparam longint UNIT_ONE = 64'd16777216;  // 1.0 in units of 2^-24
    localparam longint FULL_16  = 64'd65535;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [0:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;     // red [15:0], green [31:16], blue [47:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // data_byte [7:0]
    logic        m_tlast;

    // Local copy of the registers and the bytes still to come.
    logic        mode16_reg = 1'b0;
    logic        gray_reg = 1'b0;
    pixel_byte_t pending_bytes[$];

    int          error_count = 0;
    int          pixels_sent = 0;
    int          bytes_checked = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    int          cycle_count = 0;

    pixel_to_image_message_bytes_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Splits a half code into its class and, when finite, its exact value.
    function automatic pxb_kind_t half_class(input logic [15:0] code,
                                             output longint value);
        pxb_kind_t  kind;
        logic [4:0] expo;
        longint     mag;
        expo  = code[14:10];
        value = 0;
        kind  = KIND_FINITE;
        if (expo == 5'h1F)
        begin
            if (code[9:0] != 10'd0)
                kind = KIND_NAN;
            else if (code[15])
                kind = KIND_NINF;
            else
                kind = KIND_PINF;
        end
        else
        begin
            if (expo == 5'd0)
                mag = longint'(code[9:0]);
            else
                mag = longint'({1'b1, code[9:0]}) << (expo - 5'd1);
            value = code[15] ? -mag : mag;
        end
        return kind;
    endfunction

    // Clamps one half channel to [0,1] and scales it to 16 bits.
    function automatic logic [15:0] channel_to_unorm16(input logic [15:0] code);
        pxb_kind_t kind;
        longint    value;
        longint    scaled;
        kind = half_class(code, value);
        if (kind == KIND_NAN || kind == KIND_PINF)
            scaled = FULL_16;
        else if (kind == KIND_NINF || value <= 0)
            scaled = 0;
        else if (value >= UNIT_ONE)
            scaled = FULL_16;
        else
            scaled = (value * FULL_16) / UNIT_ONE;
        return scaled[15:0];
    endfunction

    // Clamps the average of three half channels and scales it to 16 bits.
    function automatic logic [15:0] average_to_unorm16(input logic [15:0] r,
                                                       input logic [15:0] g,
                                                       input logic [15:0] b);
        logic [15:0] codes[3];
        pxb_kind_t   kind;
        longint      value;
        longint      sum;
        longint      scaled;
        logic        any_nan;
        logic        any_pinf;
        logic        any_ninf;
        codes[0] = r;
        codes[1] = g;
        codes[2] = b;
        sum      = 0;
        any_nan  = 1'b0;
        any_pinf = 1'b0;
        any_ninf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            kind = half_class(codes[i], value);
            case (kind)
                KIND_NAN:  any_nan = 1'b1;
                KIND_PINF: any_pinf = 1'b1;
                KIND_NINF: any_ninf = 1'b1;
                default:   sum += value;
            endcase
        end
        // NaN anywhere, or +inf alone or against -inf, saturates high.
        if (any_nan || any_pinf)
            scaled = FULL_16;
        else if (any_ninf || sum <= 0)
            scaled = 0;
        else if (sum >= 3 * UNIT_ONE)
            scaled = FULL_16;
        else
            scaled = (sum * FULL_16) / (3 * UNIT_ONE);
        return scaled[15:0];
    endfunction

    // Appends the bytes that one pixel must produce under the current setting.
    function automatic void push_pixel_bytes(input logic [15:0] r,
                                             input logic [15:0] g,
                                             input logic [15:0] b);
        logic [7:0]  bytes[$];
        logic [15:0] word;
        int          gray_sum;
        pixel_byte_t item;
        if (!mode16_reg)
        begin
            if (gray_reg)
            begin
                gray_sum = int'(r[7:0]) + int'(g[7:0]) + int'(b[7:0]);
                bytes.push_back(8'(gray_sum / 3));
            end
            else
            begin
                bytes.push_back(r[7:0]);
                bytes.push_back(g[7:0]);
                bytes.push_back(b[7:0]);
            end
        end
        else if (gray_reg)
        begin
            word = average_to_unorm16(r, g, b);
            bytes.push_back(word[7:0]);
            bytes.push_back(word[15:8]);
        end
        else
        begin
            word = channel_to_unorm16(r);
            bytes.push_back(word[7:0]);
            bytes.push_back(word[15:8]);
            word = channel_to_unorm16(g);
            bytes.push_back(word[7:0]);
            bytes.push_back(word[15:8]);
            word = channel_to_unorm16(b);
            bytes.push_back(word[7:0]);
            bytes.push_back(word[15:8]);
        end
        for (int i = 0; i < bytes.size(); i++)
        begin
            item.data = bytes[i];
            item.last = (i == bytes.size() - 1);
            pending_bytes.push_back(item);
        end
    endfunction

    // Sends one pixel, with a random gap whenever the current burst runs out.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        if (burst_left == 0)
        begin
            if (s_tvalid)
                s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_tready);
        push_pixel_bytes(r, g, b);
        pixels_sent++;
    endtask

    // Waits until every expected byte has arrived and the pipeline is empty.
    task automatic drain;
        if (s_tvalid)
            s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic apply_setting(input logic mode16, input logic gray);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODE16;
        cfg_data  <= mode16;
        @(posedge clk);
        mode16_reg = mode16;
        cfg_index <= CFG_GRAY;
        cfg_data  <= gray;
        @(posedge clk);
        gray_reg = gray;
        cfg_we   <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    // Random half code, biased toward the clamp range and the special codes.
    function automatic logic [15:0] random_half;
        logic [15:0] code;
        code = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0, 1, 2:
                code = {1'b0, 5'($urandom_range(0, 14)), 10'($urandom_range(0, 1023))};
            3:
                code = {6'b011111, 10'($urandom_range(0, 1023))};
            4:
                code = {6'b111111, 10'($urandom_range(0, 1023))};
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       code = 16'h3BFF;
                    1:       code = 16'h3C00;
                    2:       code = 16'h3C01;
                    3:       code = 16'h0000;
                    4:       code = 16'h8000;
                    default: code = 16'h7BFF;
                endcase
            end
            6:
                code = {1'b1, 5'($urandom_range(0, 15)), 10'($urandom_range(0, 1023))};
            default:
                code = 16'($urandom_range(0, 65535));
        endcase
        return code;
    endfunction

    // Random 8-bit channel; the upper byte is random too and must be ignored.
    function automatic logic [15:0] random_byte_channel;
        logic [15:0] code;
        code = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       code[7:0] = 8'h00;
            1:       code[7:0] = 8'hFF;
            default: ;
        endcase
        return code;
    endfunction

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (mode16_reg)
                send_pixel(random_half(), random_half(), random_half());
            else
                send_pixel(random_byte_channel(), random_byte_channel(),
                           random_byte_channel());
        end
    endtask

    // 8-bit RGB: all channels pass through, upper bits dropped.
    task automatic test_rgb8;
        apply_setting(1'b0, 1'b0);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFF00, 16'h00FF);
        send_pixel(16'h1234, 16'hAB80, 16'h7F01);
        send_random_pixels(40);
    endtask

    // 8-bit grayscale: floor of the channel average.
    task automatic test_gray8;
        apply_setting(1'b0, 1'b1);
        send_pixel(16'h00FF, 16'h00FF, 16'h00FF);
        send_pixel(16'hFF00, 16'h0001, 16'h0002);
        send_pixel(16'h0001, 16'h0001, 16'h0000);
        send_pixel(16'h00FE, 16'hF0FF, 16'h00FF);
        send_random_pixels(40);
    endtask

    // 16-bit RGB: per-channel clamp, scale and truncate.
    task automatic test_rgb16;
        apply_setting(1'b1, 1'b0);
        send_pixel(16'h7E00, 16'h7C00, 16'hFC00);  // NaN, +inf, -inf
        send_pixel(16'h8000, 16'h0000, 16'h3C00);  // -0, +0, 1.0
        send_pixel(16'h3BFF, 16'h3C01, 16'h7BFF);  // just below and above 1.0, largest finite
        send_pixel(16'h0001, 16'h03FF, 16'hFFFF);  // subnormals, negative NaN
        send_pixel(16'h3555, 16'h0400, 16'hC000);
        send_random_pixels(40);
    endtask

    // 16-bit grayscale: clamp of the average, with infinities and NaN.
    task automatic test_gray16;
        apply_setting(1'b1, 1'b1);
        send_pixel(16'h7E00, 16'h3C00, 16'h3C00);  // NaN in the sum
        send_pixel(16'h7C00, 16'hFC00, 16'h0000);  // both infinities
        send_pixel(16'h7C00, 16'hBC00, 16'hBC00);  // +inf alone
        send_pixel(16'hFC00, 16'h3C00, 16'h3C00);  // -inf alone
        send_pixel(16'hBC00, 16'h3800, 16'h0000);  // negative sum
        send_pixel(16'h3C00, 16'h3C00, 16'h3C00);  // average exactly 1.0
        send_pixel(16'h3C00, 16'h3C00, 16'h3BFF);  // just under 1.0
        send_pixel(16'h0001, 16'h0000, 16'h8000);  // smallest subnormal
        send_pixel(16'h8000, 16'h8000, 16'h8000);  // negative zeros
        send_pixel(16'h7BFF, 16'hFBFF, 16'h3800);  // largest finite values cancel
        send_random_pixels(40);
    endtask

    // Short random runs under random settings, changed between runs.
    task automatic test_setting_changes;
        for (int i = 0; i < 4; i++)
        begin
            apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_random_pixels(10);
        end
    endtask

    // Receiver back pressure: the pattern is redrawn whenever its timer runs out.
    always @(posedge clk)
    begin
        cycle_count++;
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end
        stall_timer--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (cycle_count % 4 != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compares each accepted byte with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, actual data=%02h last=%0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                if (m_tdata !== pending_bytes[0].data)
                begin
                    $display("%0t: data mismatch, expected %02h actual %02h",
                             $time, pending_bytes[0].data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== pending_bytes[0].last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, pending_bytes[0].last, m_tlast);
                    error_count++;
                end
                void'(pending_bytes.pop_front());
                bytes_checked++;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_rgb8();
        test_gray8();
        test_rgb16();
        test_gray16();
        test_setting_changes();
        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d pixels over all four settings; %0d bytes checked.",
                 pixels_sent, bytes_checked);
        $display("Errors found: %0d", error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("Timeout with %0d bytes outstanding", pending_bytes.size());
        $display("FAIL");
        $finish;
    end

endmodule
